// ===== rtl/core/circle_box_collision_resolve_assert.svh =====
// Assertion macros shared by the checker of the collision resolver.
`ifndef CIRCLE_BOX_COLLISION_RESOLVE_ASSERT_SVH
`define CIRCLE_BOX_COLLISION_RESOLVE_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define CBCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CBCR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cbcr_pkg.sv =====
// Shared types and constants of the circle versus box collision resolver.
`default_nettype none
package cbcr_pkg;
  localparam int XW        = 22;  // internal position width, never wraps
  localparam int MW        = 12;  // offset magnitude width below the radius limit
  localparam int D2W       = 25;  // squared distance width
  localparam int SQ_STEPS  = 13;  // root digits of the squared distance
  localparam int DIV_STEPS = 12;  // quotient bits of one push division
  localparam int ITW       = 4;   // iteration counter width

  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;
  localparam logic [1:0] REG_COUNT        = 2'd3;

  typedef struct packed {
    logic load_pos;
    logic wr_entry;
    logic clamp;
    logic rd_entry;
    logic near;
    logic sq_x;
    logic sq_y;
    logic snap;
    logic sq_init;
    logic sq_step;
    logic mul_x;
    logic mul_y;
    logic div_step;
    logic apply;
    logic clr_pass;
    logic load_out;
  } cbcr_cmd_t;

  typedef struct packed {
    logic far;
    logic zero;
    logic lt;
    logic hit_pass;
  } cbcr_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/cbcr_datapath.sv =====
// Datapath of the resolver: obstacle table, shared multiplier, root and divide steps.
`default_nettype none
module cbcr_datapath
  import cbcr_pkg::*;
#(
  parameter int MAX_OBSTACLES = 8,
  parameter int IW = 3
) (
  input  wire logic                clk,
  input  wire cbcr_cmd_t           cmd,
  output cbcr_stat_t               stat,
  input  wire logic [IW-1:0]       rd_idx,
  input  wire logic [2:0]          in_slot,
  input  wire logic signed [16:0]  in_pos_x,
  input  wire logic signed [16:0]  in_pos_y,
  input  wire logic [15:0]         in_rect_w,
  input  wire logic [15:0]         in_rect_h,
  input  wire logic [15:0]         world_width,
  input  wire logic [15:0]         world_height,
  input  wire logic [11:0]         circle_radius,
  output logic signed [16:0]       res_x,
  output logic signed [16:0]       res_y,
  output logic                     collided
);
  logic signed [16:0] tab_l [MAX_OBSTACLES];
  logic signed [16:0] tab_t [MAX_OBSTACLES];
  logic [15:0]        tab_w [MAX_OBSTACLES];
  logic [15:0]        tab_h [MAX_OBSTACLES];

  logic signed [XW-1:0] x, y;
  logic signed [16:0]   l, t;
  logic [15:0]          w, h;
  logic [MW-1:0]        magx, magy, quot, qx, dv_low, dv_rem;
  logic                 sgnx, sgny, far, zero, hit_pass, any;
  logic [D2W-1:0]       d2, rr;
  logic [25:0]          sq_v;
  logic [15:0]          sq_rem;
  logic [MW:0]          root;

  logic [IW+2:0]        slot_ext;
  logic                 slot_ok;
  logic signed [XW-1:0] r_ext, hi_x, hi_y, xc, yc, xc2, yc2;
  logic signed [XW-1:0] l_ext, t_ext, lw, th, cxm, cym, cx, cy, dxf, dyf, adx, ady;
  logic signed [XW:0]   tx, tl;
  logic [MW-1:0]        o, ma, mb;
  logic [2*MW-1:0]      prod;
  logic [15:0]          rem2, trial;
  logic [MW:0]          dr2;
  logic signed [XW-1:0] qxe, qye, sx, sy;

  assign slot_ext = {{IW{1'b0}}, in_slot};
  assign slot_ok  = int'(slot_ext) < MAX_OBSTACLES;

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && slot_ok) begin
      tab_l[slot_ext[IW-1:0]] <= in_pos_x;
      tab_t[slot_ext[IW-1:0]] <= in_pos_y;
      tab_w[slot_ext[IW-1:0]] <= in_rect_w;
      tab_h[slot_ext[IW-1:0]] <= in_rect_h;
    end
    if (cmd.rd_entry) begin
      l <= tab_l[rd_idx];
      t <= tab_t[rd_idx];
      w <= tab_w[rd_idx];
      h <= tab_h[rd_idx];
    end
  end

  always_comb begin
    r_ext = $signed({{(XW-12){1'b0}}, circle_radius});
    hi_x  = $signed({{(XW-16){1'b0}}, world_width}) - r_ext;
    hi_y  = $signed({{(XW-16){1'b0}}, world_height}) - r_ext;
    xc    = (x < r_ext) ? r_ext : x;
    xc2   = (xc > hi_x) ? hi_x : xc;
    yc    = (y < r_ext) ? r_ext : y;
    yc2   = (yc > hi_y) ? hi_y : yc;
    l_ext = $signed({{(XW-17){l[16]}}, l});
    t_ext = $signed({{(XW-17){t[16]}}, t});
    lw    = l_ext + $signed({{(XW-16){1'b0}}, w});
    th    = t_ext + $signed({{(XW-16){1'b0}}, h});
    cxm   = (x < lw) ? x : lw;
    cx    = (cxm < l_ext) ? l_ext : cxm;
    cym   = (y < th) ? y : th;
    cy    = (cym < t_ext) ? t_ext : cym;
    dxf   = x - cx;
    dyf   = y - cy;
    adx   = dxf[XW-1] ? -dxf : dxf;
    ady   = dyf[XW-1] ? -dyf : dyf;
    tx    = $signed({x, 1'b0});
    tl    = $signed({l_ext, 1'b0}) + $signed({{(XW-15){1'b0}}, w});
    o     = circle_radius - root[MW-1:0];
    ma    = circle_radius;
    mb    = circle_radius;
    if (cmd.sq_x) begin
      ma = magx; mb = magx;
    end else if (cmd.sq_y) begin
      ma = magy; mb = magy;
    end else if (cmd.mul_x) begin
      ma = magx; mb = o;
    end else if (cmd.mul_y) begin
      ma = magy; mb = o;
    end
    prod  = ma * mb;
    rem2  = {sq_rem[13:0], sq_v[25:24]};
    trial = {1'b0, root, 2'b01};
    dr2   = {dv_rem, dv_low[MW-1]};
    qxe   = $signed({{(XW-MW){1'b0}}, qx});
    qye   = $signed({{(XW-MW){1'b0}}, quot});
    sx    = sgnx ? -qxe : qxe;
    sy    = sgny ? -qye : qye;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      x   <= $signed({{(XW-17){in_pos_x[16]}}, in_pos_x});
      y   <= $signed({{(XW-17){in_pos_y[16]}}, in_pos_y});
      any <= 1'b0;
    end
    if (cmd.clamp) begin
      x  <= xc2;
      y  <= yc2;
      rr <= {1'b0, prod};
    end
    if (cmd.near) begin
      magx <= adx[MW-1:0];
      magy <= ady[MW-1:0];
      sgnx <= dxf[XW-1];
      sgny <= dyf[XW-1];
      far  <= (|adx[XW-1:MW]) || (|ady[XW-1:MW]);
      zero <= (dxf == '0) && (dyf == '0);
    end
    if (cmd.sq_x) d2 <= {1'b0, prod};
    if (cmd.sq_y) d2 <= d2 + {1'b0, prod};
    if (cmd.clr_pass) hit_pass <= 1'b0;
    if (cmd.snap) begin
      // Center in or on the box: snap x out past the nearer vertical side.
      x        <= (tx > tl) ? lw + r_ext : l_ext - r_ext;
      hit_pass <= 1'b1;
      any      <= 1'b1;
    end
    if (cmd.sq_init) begin
      sq_v   <= {1'b0, d2};
      sq_rem <= '0;
      root   <= '0;
    end
    if (cmd.sq_step) begin
      sq_v <= {sq_v[23:0], 2'b00};
      if (rem2 >= trial) begin
        sq_rem <= rem2 - trial;
        root   <= {root[MW-1:0], 1'b1};
      end else begin
        sq_rem <= rem2;
        root   <= {root[MW-1:0], 1'b0};
      end
    end
    if (cmd.mul_x || cmd.mul_y) begin
      // Quotient stays below 2^MW, so the upper half starts below the divisor.
      dv_rem <= prod[2*MW-1:MW];
      dv_low <= prod[MW-1:0];
      quot   <= '0;
    end
    if (cmd.mul_y) qx <= quot;
    if (cmd.div_step) begin
      dv_low <= {dv_low[MW-2:0], 1'b0};
      if (dr2 >= {1'b0, root[MW-1:0]}) begin
        dv_rem <= MW'(dr2 - {1'b0, root[MW-1:0]});
        quot   <= {quot[MW-2:0], 1'b1};
      end else begin
        dv_rem <= dr2[MW-1:0];
        quot   <= {quot[MW-2:0], 1'b0};
      end
    end
    if (cmd.apply) begin
      x        <= x + sx;
      y        <= y + sy;
      hit_pass <= 1'b1;
      any      <= 1'b1;
    end
    if (cmd.load_out) begin
      res_x    <= (x < -XW'(65536)) ? -17'sd65536 : ((x > XW'(65535)) ? 17'sd65535 : x[16:0]);
      res_y    <= (y < -XW'(65536)) ? -17'sd65536 : ((y > XW'(65535)) ? 17'sd65535 : y[16:0]);
      collided <= any;
    end
  end

  assign stat.far      = far;
  assign stat.zero     = zero;
  assign stat.lt       = d2 < rr;
  assign stat.hit_pass = hit_pass;
endmodule
`default_nettype wire

// ===== rtl/core/cbcr_ctrl.sv =====
// Sequencer of the resolver: passes, obstacles, root and divide iterations, handshakes.
`default_nettype none
module cbcr_ctrl
  import cbcr_pkg::*;
#(
  parameter int MAX_OBSTACLES = 8,
  parameter int PASS_LIMIT = 4,
  parameter int IW = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic          s_op,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire logic [3:0]    obstacle_count,
  input  wire cbcr_stat_t    stat,
  output cbcr_cmd_t          cmd,
  output logic [IW-1:0]      rd_idx
);
  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int PW = $clog2(PASS_LIMIT + 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CLAMP  = 16'h0002,
    S_PASS   = 16'h0004,
    S_CHECK  = 16'h0008,
    S_RD     = 16'h0010,
    S_NEAR   = 16'h0020,
    S_SQX    = 16'h0040,
    S_SQY    = 16'h0080,
    S_DECIDE = 16'h0100,
    S_SQRT   = 16'h0200,
    S_MULX   = 16'h0400,
    S_DIVX   = 16'h0800,
    S_MULY   = 16'h1000,
    S_DIVY   = 16'h2000,
    S_APPLY  = 16'h4000,
    S_FINISH = 16'h8000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  cnt, idx;
  logic [PW-1:0]  pass;
  logic [ITW-1:0] it;
  logic           acc;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign rd_idx   = idx[IW-1:0];

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.wr_entry = acc && s_op;
        cmd.load_pos = acc && !s_op;
        if (acc && !s_op) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_PASS;
      end
      S_PASS: begin
        cmd.clr_pass = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (idx < cnt) state_next = S_RD;
        else if (stat.hit_pass && (int'(pass) + 1 < PASS_LIMIT)) state_next = S_PASS;
        else state_next = S_FINISH;
      end
      S_RD: begin
        cmd.rd_entry = 1'b1;
        state_next   = S_NEAR;
      end
      S_NEAR: begin
        cmd.near   = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.far) state_next = S_CHECK;
        else if (stat.zero) begin
          cmd.snap   = 1'b1;
          state_next = S_CHECK;
        end else if (stat.lt) begin
          cmd.sq_init = 1'b1;
          state_next  = S_SQRT;
        end else state_next = S_CHECK;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (it == ITW'(SQ_STEPS - 1)) state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        if (it == ITW'(DIV_STEPS - 1)) state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        if (it == ITW'(DIV_STEPS - 1)) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_CHECK;
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      idx      <= '0;
      pass     <= '0;
      it       <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cmd.load_pos) begin
        cnt  <= (int'(obstacle_count) > MAX_OBSTACLES) ? CW'(MAX_OBSTACLES)
                                                         : CW'(obstacle_count);
        pass <= '0;
      end
      if (cmd.clr_pass) idx <= '0;
      if (state == S_CHECK && idx >= cnt) pass <= pass + 1'b1;
      if (state_next == S_CHECK && state != S_PASS && state != S_CHECK) idx <= idx + 1'b1;
      // The step counter runs while an iterating state repeats and clears on its exit.
      if ((cmd.sq_step || cmd.div_step) && state_next == state) it <= it + 1'b1;
      else it <= '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/circle_box_collision_resolve.sv =====
// Top level of the circle versus box collision resolver with its register port.
// An obstacle write is taken while idle; a resolve runs at most PASS_LIMIT passes
// over the active obstacles. A pushing obstacle costs a 13-step root and two 12-step
// divides; every product of a resolve comes from one shared multiplier.
// One position word is in flight at a time; the next is taken when the result is loaded.
// Reset is synchronous and active high; it restores the registers and leaves the table.
`default_nettype none
module circle_box_collision_resolve
  import cbcr_pkg::*;
#(
  parameter int MAX_OBSTACLES = 8,
  parameter int PASS_LIMIT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // slot[2:0], pos_x[19:3], pos_y[36:20], rect_w[52:37], rect_h[68:53], zeros above
  input  wire logic [71:0] s_tdata,
  // op[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // res_x[16:0], res_y[33:17], zeros above
  output logic [39:0]      m_tdata,
  // collided[0]
  output logic [0:0]       m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  logic [15:0]        world_width, world_height;
  logic [11:0]        circle_radius;
  logic [3:0]         obstacle_count;
  cbcr_cmd_t          cmd;
  cbcr_stat_t         stat;
  logic [IW-1:0]      rd_idx;
  logic signed [16:0] res_x, res_y;
  logic               collided;

  assign pready = 1'b1;

  // Configuration writes land in the access cycle of the bus transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width    <= 16'd19200;
      world_height   <= 16'd11520;
      circle_radius  <= 12'd240;
      obstacle_count <= 4'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WORLD_WIDTH:  world_width    <= pwdata[15:0];
        REG_WORLD_HEIGHT: world_height   <= pwdata[15:0];
        REG_RADIUS:       circle_radius  <= pwdata[11:0];
        REG_COUNT:        obstacle_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WORLD_WIDTH:  prdata = {16'd0, world_width};
      REG_WORLD_HEIGHT: prdata = {16'd0, world_height};
      REG_RADIUS:       prdata = {20'd0, circle_radius};
      REG_COUNT:        prdata = {28'd0, obstacle_count};
      default:          prdata = '0;
    endcase
  end

  // The controller sequences passes and obstacles; the datapath holds table and position.
  cbcr_ctrl #(
    .MAX_OBSTACLES(MAX_OBSTACLES),
    .PASS_LIMIT(PASS_LIMIT),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_op(s_tuser[0]),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .obstacle_count(obstacle_count),
    .stat(stat),
    .cmd(cmd),
    .rd_idx(rd_idx)
  );

  cbcr_datapath #(
    .MAX_OBSTACLES(MAX_OBSTACLES),
    .IW(IW)
  ) u_dp (
    .clk(clk),
    .cmd(cmd),
    .stat(stat),
    .rd_idx(rd_idx),
    .in_slot(s_tdata[2:0]),
    .in_pos_x(s_tdata[19:3]),
    .in_pos_y(s_tdata[36:20]),
    .in_rect_w(s_tdata[52:37]),
    .in_rect_h(s_tdata[68:53]),
    .world_width(world_width),
    .world_height(world_height),
    .circle_radius(circle_radius),
    .res_x(res_x),
    .res_y(res_y),
    .collided(collided)
  );

  // The result word is held in the datapath output register until taken.
  assign m_tdata = {6'd0, res_y, res_x};
  assign m_tuser = collided;
endmodule
`default_nettype wire

// ===== rtl/core/cbcr_checker.sv =====
// Port-level checker of the collision resolver and its bind to the top level.
`default_nettype none
`include "circle_box_collision_resolve_assert.svh"
module cbcr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        pready
);
  `CBCR_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `CBCR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `CBCR_ASSERT(a_write_no_busy, s_tvalid && s_tready && s_tuser[0] |=> s_tready, "table write made the block busy")
  `CBCR_ASSERT(a_resolve_busy, s_tvalid && s_tready && !s_tuser[0] |=> !s_tready && !$rose(m_tvalid), "resolve did not start")
  `CBCR_ASSERT_RST(a_pready, pready, "register port not ready")
endmodule

bind circle_box_collision_resolve cbcr_checker u_cbcr_checker (.*);
`default_nettype wire

// ===== sim/tb_circle_box_collision_resolve.sv =====
// Self-checking testbench of the circle versus box collision resolver.
`default_nettype none
module tb_circle_box_collision_resolve;
  import cbcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS = 8;
  localparam int PASSES    = 4;
  localparam int DOG_LIMIT = 40000;   // idle cycles before the run is declared hung
  localparam int SETTLE    = 20;      // cycles for a trailing obstacle write to land

  typedef enum logic { OP_RESOLVE = 1'b0, OP_WRITE = 1'b1 } op_e;
  typedef enum logic { ROW_WORD, ROW_REG } row_kind_e;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               hit;
  } place_t;

  typedef struct {
    row_kind_e  kind;
    op_e        op;
    int         slot;     // obstacle slot, or register index for a register row
    int         px;       // x or left edge, or register value
    int         py;
    int         w;
    int         h;
    bit         typed;    // expected result written in the row
    place_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  circle_box_collision_resolve dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of the configuration and of the obstacle table.
  longint world_w, world_h, radius, active_cnt;
  longint obs_l [MAX_SLOTS];
  longint obs_t [MAX_SLOTS];
  longint obs_w [MAX_SLOTS];
  longint obs_h [MAX_SLOTS];

  place_t pending_places [$];
  int     fail_cnt = 0;
  int     resolves = 0, pushed = 0, table_writes = 0;
  bit     steady = 1'b0;   // when set, neither side idles

  // Integer square root, rounded down, one result bit per step.
  function automatic longint floor_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [16:0] sat17(longint v);
    if (v < -65536) v = -65536;
    if (v > 65535) v = 65535;
    return v[16:0];
  endfunction

  // Clamp to the shrunk world, then push the circle out of every active
  // obstacle, pass after pass, until a pass moves nothing or PASSES have run.
  function automatic place_t resolve_place(longint x, longint y);
    place_t p;
    longint hi, l, t, w, h, cx, cy, dx, dy, d2, d, o;
    int     n;
    bit     moved, any;
    any = 1'b0;
    hi = world_w - radius;
    if (x < radius) x = radius;
    if (x > hi) x = hi;
    hi = world_h - radius;
    if (y < radius) y = radius;
    if (y > hi) y = hi;
    n = (active_cnt > MAX_SLOTS) ? MAX_SLOTS : int'(active_cnt);
    for (int pass = 0; pass < PASSES; pass++) begin
      moved = 1'b0;
      for (int i = 0; i < n; i++) begin
        l = obs_l[i]; t = obs_t[i]; w = obs_w[i]; h = obs_h[i];
        cx = (x < l + w) ? x : l + w;
        if (cx < l) cx = l;
        cy = (y < t + h) ? y : t + h;
        if (cy < t) cy = t;
        dx = x - cx;
        dy = y - cy;
        d2 = dx * dx + dy * dy;
        if (d2 > 0 && d2 < radius * radius) begin
          d = floor_sqrt(d2);
          o = radius - d;
          x = x + (dx * o) / d;
          y = y + (dy * o) / d;
          moved = 1'b1;
        end else if (d2 == 0) begin
          // Center on or in the box: jump to the nearer vertical side.
          x = (2 * x > 2 * l + w) ? l + w + radius : l - radius;
          moved = 1'b1;
        end
      end
      if (!moved) break;
      any = 1'b1;
    end
    p.x = sat17(x);
    p.y = sat17(y);
    p.hit = any;
    return p;
  endfunction

  // Register write over the APB port: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, int value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WORLD_WIDTH:  world_w = value & 32'hFFFF;
      REG_WORLD_HEIGHT: world_h = value & 32'hFFFF;
      REG_RADIUS:       radius = value & 32'hFFF;
      REG_COUNT:        active_cnt = value & 32'hF;
      default: ;
    endcase
  endtask

  // Present one word, wait for the handshake and update the predictor.
  // Valid is left high; a following word may reuse it without a drop.
  task automatic send_word(op_e op, int slot, int px, int py, int w, int h,
                           bit typed, place_t want);
    logic [16:0] xb, yb;
    place_t      calc;
    place_t      keep;
    xb = px[16:0];
    yb = py[16:0];
    while (!steady && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b000, h[15:0], w[15:0], yb, xb, slot[2:0]};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (op == OP_WRITE) begin
      obs_l[slot[2:0]] = $signed(xb);
      obs_t[slot[2:0]] = $signed(yb);
      obs_w[slot[2:0]] = w & 32'hFFFF;
      obs_h[slot[2:0]] = h & 32'hFFFF;
      table_writes++;
    end else begin
      calc = resolve_place($signed(xb), $signed(yb));
      if (typed) keep = want;
      else keep = calc;
      pending_places.insert(pending_places.size(), keep);
      resolves++;
      if (calc.hit) pushed++;
    end
  endtask

  // Drop valid and let the block drain before a register is touched.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_places.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Handshakes are sampled at the falling edge, where every signal is settled,
  // and acted on at the next rising edge.
  logic in_fire_n, out_fire_n, reg_fire_n;
  logic [39:0] out_data_n;
  logic [0:0]  out_user_n;
  int          dog = 0;

  always @(negedge clk) begin
    in_fire_n  <= s_tvalid && s_tready;
    out_fire_n <= m_tvalid && m_tready;
    reg_fire_n <= psel && penable;
    out_data_n <= m_tdata;
    out_user_n <= m_tuser;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 29);
    end
  end

  // Result checker: every word is matched against the oldest expectation.
  always @(posedge clk) begin
    place_t      exp_p;
    logic [16:0] got_x, got_y;
    if (!rst && out_fire_n === 1'b1) begin
      got_x = out_data_n[16:0];
      got_y = out_data_n[33:17];
      if (pending_places.size() == 0) begin
        $display("%0t: result word with nothing expected, x=%0d y=%0d collided=%0d",
                 $realtime, $signed(got_x), $signed(got_y), out_user_n[0]);
        fail_cnt++;
      end else begin
        exp_p = pending_places.pop_front();
        if (got_x !== exp_p.x) begin
          $display("%0t: res_x expected %0d got %0d", $realtime, exp_p.x, $signed(got_x));
          fail_cnt++;
        end
        if (got_y !== exp_p.y) begin
          $display("%0t: res_y expected %0d got %0d", $realtime, exp_p.y, $signed(got_y));
          fail_cnt++;
        end
        if (out_user_n[0] !== exp_p.hit) begin
          $display("%0t: collided expected %0d got %0d", $realtime, exp_p.hit,
                   out_user_n[0]);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on any port means a hang.
  always @(posedge clk) begin
    if (rst || in_fire_n === 1'b1 || out_fire_n === 1'b1 || reg_fire_n === 1'b1) begin
      dog <= 0;
    end else begin
      dog <= dog + 1;
      if (dog >= DOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, DOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Directed words: clamps against the default world, a table fill that covers
  // the field extremes, a center inside a box, a zero radius, a count above the
  // table size and a world narrower than the circle, where the high bound wins.
  dir_row_t dir_tab [] = '{
    '{ROW_WORD, OP_RESOLVE, 0, 0, 0, 0, 0, 1'b1, '{17'sd240, 17'sd240, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 65535, 65535, 0, 0, 1'b1, '{17'sd18960, 17'sd11280, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, -65536, -65536, 0, 0, 1'b1, '{17'sd240, 17'sd240, 1'b0}},
    '{ROW_WORD, OP_WRITE, 0, 1000, 1000, 2000, 1000, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 1, 4000, 3000, 500, 500, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 2, -65536, -65536, 65535, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 3, 10000, 8000, 0, 65535, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 4, 65535, 65535, 1, 1, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 5, 6000, 1000, 300, 2000, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 6, 15000, 500, 1000, 100, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_WRITE, 7, 2000, 6000, 800, 800, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_COUNT), 8, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 2000, 1500, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 4250, 2700, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 9900, 9000, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 3000, 5000, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_RADIUS), 0, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 1500, 1500, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_COUNT), 15, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_RADIUS), 4095, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_WORLD_WIDTH), 0, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 500, 500, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_WORLD_WIDTH), 65535, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_WORLD_HEIGHT), 65535, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_RADIUS), 240, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_REG, OP_RESOLVE, int'(REG_COUNT), 8, 0, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, 65535, 65535, 0, 0, 1'b0, '{0, 0, 1'b0}},
    '{ROW_WORD, OP_RESOLVE, 0, -65536, 70, 0, 0, 1'b0, '{0, 0, 1'b0}}
  };

  initial begin
    place_t none;
    int     s, px, py, lim, tail;
    none = '{0, 0, 1'b0};
    world_w = 19200; world_h = 11520; radius = 240; active_cnt = 0;
    foreach (obs_l[i]) begin
      obs_l[i] = 0; obs_t[i] = 0; obs_w[i] = 0; obs_h[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_tab[i].slot[1:0], dir_tab[i].px);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].slot, dir_tab[i].px, dir_tab[i].py,
                  dir_tab[i].w, dir_tab[i].h, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases: a fresh setting, then positions aimed mostly at the active
    // boxes so that pushes and chains happen, mixed with some table rewrites.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      steady = (ph == 2);
      case ($urandom_range(3))
        0: write_reg(REG_WORLD_WIDTH, $urandom_range(1) ? 0 : 65535);
        default: write_reg(REG_WORLD_WIDTH, $urandom_range(40000, 2000));
      endcase
      write_reg(REG_WORLD_HEIGHT, ($urandom_range(5) == 0) ? $urandom_range(65535)
                                                             : $urandom_range(30000, 2000));
      case ($urandom_range(7))
        0: write_reg(REG_RADIUS, $urandom_range(1) ? 0 : 4095);
        1: write_reg(REG_RADIUS, $urandom_range(4095));
        default: write_reg(REG_RADIUS, $urandom_range(600, 16));
      endcase
      write_reg(REG_COUNT, ($urandom_range(7) == 0) ? $urandom_range(15, 9)
                                                    : $urandom_range(8));
      for (int k = 0; k < 60; k++) begin
        lim = (active_cnt > MAX_SLOTS) ? MAX_SLOTS : int'(active_cnt);
        if ($urandom_range(9) == 0) begin
          s = $urandom_range(MAX_SLOTS - 1);
          if ($urandom_range(4) == 0)
            send_word(OP_WRITE, s, $urandom_range(131071), $urandom_range(131071),
                      $urandom_range(65535), $urandom_range(65535), 1'b0, none);
          else
            send_word(OP_WRITE, s, $urandom_range(int'(world_w)), $urandom_range(int'(world_h)),
                      $urandom_range(3000), $urandom_range(3000), 1'b0, none);
        end else if (lim > 0 && $urandom_range(9) < 7) begin
          s = $urandom_range(lim - 1);
          px = int'(obs_l[s]) - int'(radius) - 40 +
               $urandom_range(int'(obs_w[s] + 2 * radius) + 80);
          py = int'(obs_t[s]) - int'(radius) - 40 +
               $urandom_range(int'(obs_h[s] + 2 * radius) + 80);
          send_word(OP_RESOLVE, 0, px, py, 0, 0, 1'b0, none);
        end else begin
          send_word(OP_RESOLVE, $urandom_range(7), $urandom_range(131071),
                    $urandom_range(131071), $urandom_range(65535), $urandom_range(65535),
                    1'b0, none);
        end
      end
    end

    s_tvalid <= 1'b0;
    steady = 1'b0;
    tail = 0;
    while (pending_places.size() != 0) @(posedge clk);
    while (tail < 200) begin
      @(posedge clk);
      tail++;
    end
    $display("Resolved %0d positions (%0d pushed by a box), wrote %0d table entries,",
             resolves, pushed, table_writes);
    $display("across directed corner cases and 12 random register settings.");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
